// ===== sv/pqts_pkg.sv =====
// pqts_pkg: shared constants, request codes and channel payload types for the
// piecewise quintic trajectory sampler. No dependencies.

package pqts_pkg;

   localparam int MAX_SEGMENTS   = 16;
   localparam int FRAC_BITS      = 16;
   localparam int SLOTS_PER_SEG  = 12;
   localparam int COEFS_PER_AXIS = 6;
   localparam int NUM_CHAINS     = 6;
   localparam int DATA_W         = 32;
   localparam int IDX_W          = $clog2(MAX_SEGMENTS);
   localparam int CNT_W          = $clog2(MAX_SEGMENTS + 1);
   localparam int COEF_DEPTH     = MAX_SEGMENTS * SLOTS_PER_SEG;
   localparam int CADDR_W        = $clog2(COEF_DEPTH);

   typedef enum logic [1:0] {
      REQ_CLEAR  = 2'd0,
      REQ_APPEND = 2'd1,
      REQ_WRITE  = 2'd2,
      REQ_SAMPLE = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_PAST_END = 2'd2,
      ST_REJECT   = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]               req_type;
      logic [3:0]               segment;
      logic [3:0]               slot;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] sample_time;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] pos_x;
      logic signed [DATA_W-1:0] pos_y;
      logic signed [DATA_W-1:0] vel_x;
      logic signed [DATA_W-1:0] vel_y;
      logic signed [DATA_W-1:0] acc_x;
      logic signed [DATA_W-1:0] acc_y;
      logic [1:0]               status;
   } rsp_payload_type;

endpackage

// ===== sv/pqts_req_if.sv =====
// pqts_req_if: valid/ready request channel of the trajectory sampler.
// Depends on pqts_pkg for the payload type.

interface pqts_req_if import pqts_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/pqts_rsp_if.sv =====
// pqts_rsp_if: valid/ready result channel of the trajectory sampler.
// Depends on pqts_pkg for the payload type.

interface pqts_rsp_if import pqts_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/pqts_ram.sv =====
// pqts_ram: generic single-write, single-read memory with registered read data.
// No dependencies.

module pqts_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 16,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/piecewise_quintic_trajectory_sampler.sv =====
// piecewise_quintic_trajectory_sampler: top level, request sequencer, segment
// search and shared Horner multiply-accumulate unit.
// Depends on pqts_pkg, pqts_req_if, pqts_rsp_if and pqts_ram.

// The block holds up to MAX_SEGMENTS two-axis quintic segments (a duration
// and twelve coefficients each, in two memories) and answers one request at a
// time with one result. Clear, append and coefficient writes go straight to
// the done state. A sample walks the stored durations with one duration
// memory read and one compare per segment visited (none for a negative time),
// then evaluates six Horner chains (position, velocity and acceleration for x
// and y) on a single 32x32 multiplier: a coefficient read, the first term,
// then one multiply and one add for each further coefficient, 30 coefficients
// in all. Request ready is high only while the sequencer is idle; a finished
// result sits in an output register, so the next request is taken while it
// waits.

module piecewise_quintic_trajectory_sampler import pqts_pkg::*; (
   input logic        clock,
   input logic        reset,
   pqts_req_if.sink   req_chan,
   pqts_rsp_if.source rsp_chan
);

   localparam int WC_W  = DATA_W + 5;
   localparam int SUM_W = DATA_W + IDX_W + 1;
   localparam int PROD_W = 2 * DATA_W;
   localparam int FLR_W = PROD_W - FRAC_BITS;
   localparam int SAT_W = FLR_W + 2;

   localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(32'sh7FFF_FFFF);
   localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(32'sh8000_0000);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_HRD,
      S_HFIRST,
      S_HMUL,
      S_HADD,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      KIND_POS = 2'd0,
      KIND_VEL = 2'd1,
      KIND_ACC = 2'd2
   } kind_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI;
      end else if (v < SAT_LO) begin
         r = SAT_LO;
      end else begin
         r = v;
      end
      return r[DATA_W-1:0];
   endfunction

   // weighted coefficient k*c, weights built from shifts and adds
   function automatic logic signed [WC_W-1:0] wmul(input logic signed [DATA_W-1:0] c,
                                                   input kind_type kind,
                                                   input logic [2:0] step);
      logic signed [WC_W-1:0] cx;
      logic signed [WC_W-1:0] r;
      cx = {{(WC_W - DATA_W){c[DATA_W-1]}}, c};
      r  = cx;
      case (kind)
         KIND_VEL: begin
            case (step)
               3'd0:    r = (cx <<< 2) + cx;
               3'd1:    r = cx <<< 2;
               3'd2:    r = (cx <<< 1) + cx;
               3'd3:    r = cx <<< 1;
               default: r = cx;
            endcase
         end
         KIND_ACC: begin
            case (step)
               3'd0:    r = (cx <<< 4) + (cx <<< 2);
               3'd1:    r = (cx <<< 3) + (cx <<< 2);
               3'd2:    r = (cx <<< 2) + (cx <<< 1);
               default: r = cx <<< 1;
            endcase
         end
         default: r = cx;
      endcase
      return r;
   endfunction

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [CADDR_W-1:0]        base_ff, base_in;
   logic signed [SUM_W-1:0]   start_ff, start_in;
   logic signed [DATA_W-1:0]  t_ff, t_in;
   logic signed [DATA_W-1:0]  acc_ff, acc_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [2:0]                chain_ff, chain_in;
   logic [2:0]                step_ff, step_in;
   logic signed [DATA_W-1:0]  res_ff [NUM_CHAINS];
   logic signed [DATA_W-1:0]  res_in [NUM_CHAINS];
   status_type                status_ff, status_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_data_ff, rsp_data_in;

   logic                      req_accept;
   req_payload_type           req_pl;
   logic                      dur_we;
   logic                      coef_we;
   logic                      write_ok;
   logic [CADDR_W-1:0]        coef_waddr;
   logic [CADDR_W-1:0]        coef_raddr;
   logic [DATA_W-1:0]         dur_rdata;
   logic [DATA_W-1:0]         coef_rdata;
   kind_type                  kind;
   logic [2:0]                last_step;
   logic signed [SUM_W-1:0]   dur_ext;
   logic signed [SUM_W-1:0]   seg_end;
   logic signed [SUM_W-1:0]   t_ext;
   logic signed [SUM_W:0]     local_diff;
   logic signed [FLR_W-1:0]   prod_floor;
   logic signed [SAT_W-1:0]   horner_sum;
   logic signed [SAT_W-1:0]   first_term;
   logic signed [WC_W-1:0]    coef_term;
   logic signed [PROD_W-1:0]  acc_wide;
   logic signed [PROD_W-1:0]  t_wide;

   assign req_pl     = req_chan.payload;
   assign req_accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready  = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   assign write_ok = (int'(req_pl.slot) < SLOTS_PER_SEG) &&
                     (int'(req_pl.segment) < MAX_SEGMENTS);
   assign coef_waddr = CADDR_W'(req_pl.segment) * CADDR_W'(SLOTS_PER_SEG) +
                       CADDR_W'(req_pl.slot);

   assign kind = kind_type'(chain_ff[2:1]);
   always_comb begin
      case (kind)
         KIND_POS: last_step = 3'd5;
         KIND_VEL: last_step = 3'd4;
         default:  last_step = 3'd3;
      endcase
   end

   // y coefficients sit six slots above x in each segment row
   assign coef_raddr = base_ff + (chain_ff[0] ? CADDR_W'(COEFS_PER_AXIS) : '0) +
                       CADDR_W'(step_ff);

   assign dur_ext    = {{(SUM_W - DATA_W){dur_rdata[DATA_W-1]}}, dur_rdata};
   assign seg_end    = start_ff + dur_ext;
   assign t_ext      = {{(SUM_W - DATA_W){t_ff[DATA_W-1]}}, t_ff};
   assign local_diff = {t_ext[SUM_W-1], t_ext} - {start_ff[SUM_W-1], start_ff};

   assign acc_wide   = {{(PROD_W - DATA_W){acc_ff[DATA_W-1]}}, acc_ff};
   assign t_wide     = {{(PROD_W - DATA_W){t_ff[DATA_W-1]}}, t_ff};
   // arithmetic right shift is the floor of the scaled product
   assign prod_floor = prod_ff[PROD_W-1:FRAC_BITS];
   assign coef_term  = wmul(coef_rdata, kind, step_ff);
   assign first_term = {{(SAT_W - WC_W){coef_term[WC_W-1]}}, coef_term};
   assign horner_sum = {{(SAT_W - FLR_W){prod_floor[FLR_W-1]}}, prod_floor} + first_term;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      base_in      = base_ff;
      start_in     = start_ff;
      t_in         = t_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      chain_in     = chain_ff;
      step_in      = step_ff;
      res_in       = res_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      dur_we       = 1'b0;
      coef_we      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               for (int k = 0; k < NUM_CHAINS; k++) begin
                  res_in[k] = '0;
               end
               status_in = ST_OK;
               chain_in  = '0;
               step_in   = '0;
               state_in  = S_DONE;
               case (req_code_type'(req_pl.req_type))
                  REQ_CLEAR: begin
                     count_in = '0;
                  end
                  REQ_APPEND: begin
                     if (count_ff < CNT_W'(MAX_SEGMENTS)) begin
                        dur_we   = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        status_in = ST_REJECT;
                     end
                  end
                  REQ_WRITE: begin
                     if (write_ok) begin
                        coef_we = 1'b1;
                     end else begin
                        status_in = ST_REJECT;
                     end
                  end
                  REQ_SAMPLE: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else if (req_pl.sample_time[DATA_W-1]) begin
                        // negative time: first segment at its start
                        t_in     = '0;
                        base_in  = '0;
                        state_in = S_HRD;
                     end else begin
                        t_in     = req_pl.sample_time;
                        idx_in   = '0;
                        start_in = '0;
                        state_in = S_SRCH_RD;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end

         S_SRCH_RD: begin
            state_in = S_SRCH_CMP;
         end

         S_SRCH_CMP: begin
            base_in = CADDR_W'(idx_ff) * CADDR_W'(SLOTS_PER_SEG);
            if (t_ext <= seg_end) begin
               t_in     = sat32({{(SAT_W - SUM_W - 1){local_diff[SUM_W]}}, local_diff});
               state_in = S_HRD;
            end else if (CNT_W'(idx_ff) + CNT_W'(1) == count_ff) begin
               // past the end: last segment at its own duration
               t_in      = dur_rdata;
               status_in = ST_PAST_END;
               state_in  = S_HRD;
            end else begin
               start_in = seg_end;
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_SRCH_RD;
            end
         end

         S_HRD: begin
            state_in = S_HFIRST;
         end

         S_HFIRST: begin
            acc_in   = sat32(first_term);
            step_in  = 3'd1;
            state_in = S_HMUL;
         end

         S_HMUL: begin
            prod_in  = acc_wide * t_wide;
            state_in = S_HADD;
         end

         S_HADD: begin
            acc_in = sat32(horner_sum);
            if (step_ff == last_step) begin
               res_in[chain_ff] = sat32(horner_sum);
               step_in = '0;
               if (chain_ff == 3'(NUM_CHAINS - 1)) begin
                  state_in = S_DONE;
               end else begin
                  chain_in = chain_ff + 3'd1;
                  state_in = S_HRD;
               end
            end else begin
               step_in  = step_ff + 3'd1;
               state_in = S_HMUL;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_data_in.pos_x  = res_ff[0];
               rsp_data_in.pos_y  = res_ff[1];
               rsp_data_in.vel_x  = res_ff[2];
               rsp_data_in.vel_y  = res_ff[3];
               rsp_data_in.acc_x  = res_ff[4];
               rsp_data_in.acc_y  = res_ff[5];
               rsp_data_in.status = status_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      base_ff     <= base_in;
      start_ff    <= start_in;
      t_ff        <= t_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      chain_ff    <= chain_in;
      step_ff     <= step_in;
      res_ff      <= res_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   pqts_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_SEGMENTS)
   ) u_dur_ram (
      .clock   (clock),
      .wr_en   (dur_we),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_pl.value),
      .rd_addr (idx_ff),
      .rd_data (dur_rdata)
   );

   pqts_ram #(
      .WIDTH (DATA_W),
      .DEPTH (COEF_DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_waddr),
      .wr_data (req_pl.value),
      .rd_addr (coef_raddr),
      .rd_data (coef_rdata)
   );

endmodule
